// ===== rtl/hcbd_pkg.sv =====
// Shared types, constants and helpers of the HTTP chunked body decoder.
package hcbd_pkg;

    localparam int CHUNK_BITS_DEF = 32;
    localparam int COUNT_BITS_DEF = 16;

    // result queue: a request moves on only while at most two entries are held, leaving room for its two results
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_SEMI = 8'h3B;

    typedef enum logic [3:0] {
        PH_SIZE,
        PH_EXT,
        PH_EXT_CR,
        PH_SIZE_LF,
        PH_DATA,
        PH_DATA_CR,
        PH_DATA_LF,
        PH_DRAIN
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_DONE,
        KIND_ERR
    } t_kind;

    // bit 4: byte is a hex digit, bits 3:0: its value
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'b0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

// ===== rtl/http_chunked_body_decoder.sv =====
// Top level of the HTTP chunked body decoder: byte parser and result queue.
// A request passes through the input register and then the result queue; a full queue holds it in the input register.
// Throughput: one byte per cycle while the result queue has room; a byte that gives two results is popped as two.
// The input register takes a byte whenever the result queue holds at most two entries.
// Reset (synchronous, active low) empties both stages and returns the parser to the size line.
module http_chunked_body_decoder #(
    parameter int CHUNK_BITS = hcbd_pkg::CHUNK_BITS_DEF,
    parameter int COUNT_BITS = hcbd_pkg::COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [7:0]            i_in_byte,
    input  logic                  i_end_of_buffer,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [1:0]            o_kind,
    output logic [7:0]            o_out_byte,
    output logic [COUNT_BITS-1:0] o_decoded_count,
    output logic                  o_last_of_run
);
    import hcbd_pkg::*;

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_in_eob;

    t_phase                r_phase;
    logic [CHUNK_BITS-1:0] r_chunk;
    logic [COUNT_BITS-1:0] r_total;
    logic                  r_digit;

    t_kind                 r_q_kind  [Q_DEPTH];
    logic [7:0]            r_q_byte  [Q_DEPTH];
    logic [COUNT_BITS-1:0] r_q_count [Q_DEPTH];
    logic                  r_q_last  [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] r_wr;
    logic [Q_PTR_BITS-1:0] r_rd;
    logic [Q_CNT_BITS-1:0] r_cnt;

    logic                  move;
    logic                  load;
    logic                  pop;
    logic [4:0]            hex;
    logic                  ovf;
    t_phase                n_step_phase;
    logic [CHUNK_BITS-1:0] n_chunk;
    logic [COUNT_BITS-1:0] n_total;
    logic                  n_digit;
    logic                  res_vld;
    t_kind                 res_kind;
    logic [7:0]            res_byte;
    logic                  eob_err;
    logic [1:0]            n_res;
    logic [Q_PTR_BITS-1:0] wr_b;

    assign move    = r_in_valid && (r_cnt <= Q_CNT_BITS'(Q_DEPTH - 2));
    assign o_stall = r_in_valid && !move;
    assign load    = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;

    assign hex = hex_decode(r_in_byte);
    assign ovf = r_chunk[CHUNK_BITS-1 -: 4] != 4'd0;

    // next phase before rearm
    always_comb begin
        n_step_phase = r_phase;
        unique case (r_phase)
            PH_SIZE: begin
                if (hex[4]) begin
                    n_step_phase = ovf ? PH_DRAIN : PH_SIZE;
                end else if (r_in_byte == CH_SEMI && r_digit) begin
                    n_step_phase = PH_EXT;
                end else if (r_in_byte == CH_CR && r_digit) begin
                    n_step_phase = PH_SIZE_LF;
                end else begin
                    n_step_phase = PH_DRAIN;
                end
            end
            PH_EXT: begin
                if (r_in_byte == CH_CR) n_step_phase = PH_EXT_CR;
            end
            PH_EXT_CR, PH_SIZE_LF: begin
                if (r_in_byte == CH_LF) begin
                    n_step_phase = (r_chunk == '0) ? PH_DRAIN : PH_DATA;
                end else if (r_phase == PH_EXT_CR) begin
                    n_step_phase = (r_in_byte == CH_CR) ? PH_EXT_CR : PH_EXT;
                end else begin
                    n_step_phase = PH_DRAIN;
                end
            end
            PH_DATA: begin
                if (r_chunk == CHUNK_BITS'(1)) n_step_phase = PH_DATA_CR;
            end
            PH_DATA_CR: begin
                n_step_phase = (r_in_byte == CH_CR) ? PH_DATA_LF : PH_DRAIN;
            end
            PH_DATA_LF: begin
                n_step_phase = (r_in_byte == CH_LF) ? PH_SIZE : PH_DRAIN;
            end
            default: begin
                n_step_phase = PH_DRAIN;
            end
        endcase
    end

    // datapath and results
    always_comb begin
        n_chunk  = r_chunk;
        n_total  = r_total;
        n_digit  = r_digit;
        res_vld  = 1'b0;
        res_kind = KIND_ERR;
        res_byte = 8'd0;
        unique case (r_phase)
            PH_SIZE: begin
                if (hex[4] && !ovf) begin
                    n_chunk = {r_chunk[CHUNK_BITS-5:0], hex[3:0]};
                    n_digit = 1'b1;
                end
                res_vld = n_step_phase == PH_DRAIN;
            end
            PH_EXT_CR, PH_SIZE_LF: begin
                if (r_in_byte == CH_LF) begin
                    res_vld  = r_chunk == '0;
                    res_kind = KIND_DONE;
                end else begin
                    res_vld  = r_phase == PH_SIZE_LF;
                end
            end
            PH_DATA: begin
                if (r_total != '1) n_total = r_total + COUNT_BITS'(1);
                n_chunk  = r_chunk - CHUNK_BITS'(1);
                res_vld  = 1'b1;
                res_kind = KIND_DATA;
                res_byte = r_in_byte;
            end
            PH_DATA_CR: begin
                res_vld = r_in_byte != CH_CR;
            end
            PH_DATA_LF: begin
                if (r_in_byte == CH_LF) begin
                    n_chunk = '0;
                    n_digit = 1'b0;
                end else begin
                    res_vld = 1'b1;
                end
            end
            default: begin
                res_vld = 1'b0;
            end
        endcase
        eob_err = r_in_eob && (n_step_phase != PH_DRAIN);
        n_res   = {1'b0, res_vld} + {1'b0, eob_err};
    end

    assign wr_b = r_wr + Q_PTR_BITS'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (load) begin
            r_in_valid <= 1'b1;
        end else if (move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_in_byte <= i_in_byte;
            r_in_eob  <= i_end_of_buffer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SIZE;
            r_chunk <= '0;
            r_total <= '0;
            r_digit <= 1'b0;
        end else if (move) begin
            r_phase <= r_in_eob ? PH_SIZE : n_step_phase;
            r_chunk <= r_in_eob ? '0 : n_chunk;
            r_total <= r_in_eob ? '0 : n_total;
            r_digit <= r_in_eob ? 1'b0 : n_digit;
        end
    end

    // push up to two results per request
    always_ff @(posedge i_clk) begin
        if (move && n_res != 2'd0) begin
            r_q_kind[r_wr]  <= res_vld ? res_kind : KIND_ERR;
            r_q_byte[r_wr]  <= res_vld ? res_byte : 8'd0;
            r_q_count[r_wr] <= n_total;
            r_q_last[r_wr]  <= n_res == 2'd1;
        end
        if (move && n_res == 2'd2) begin
            r_q_kind[wr_b]  <= KIND_ERR;
            r_q_byte[wr_b]  <= 8'd0;
            r_q_count[wr_b] <= n_total;
            r_q_last[wr_b]  <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (move) r_wr <= r_wr + Q_PTR_BITS'(n_res);
            if (pop) r_rd <= r_rd + Q_PTR_BITS'(1);
            r_cnt <= r_cnt + (move ? Q_CNT_BITS'(n_res) : Q_CNT_BITS'(0))
                     - (pop ? Q_CNT_BITS'(1) : Q_CNT_BITS'(0));
        end
    end

    assign o_valid         = r_cnt != '0;
    assign o_kind          = r_q_kind[r_rd];
    assign o_out_byte      = r_q_byte[r_rd];
    assign o_decoded_count = r_q_count[r_rd];
    assign o_last_of_run   = r_q_last[r_rd];

endmodule

// ===== rtl/hcbd_checker.sv =====
// Port-level checks of the HTTP chunked body decoder and their binding.
module hcbd_checker #(
    parameter int COUNT_BITS = hcbd_pkg::COUNT_BITS_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_stall,
    input logic [7:0]            i_in_byte,
    input logic                  i_end_of_buffer,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic [1:0]            o_kind,
    input logic [7:0]            o_out_byte,
    input logic [COUNT_BITS-1:0] o_decoded_count,
    input logic                  o_last_of_run
);
    import hcbd_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_out_byte)
            && $stable(o_decoded_count) && $stable(o_last_of_run))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_valid && !o_stall)
        else $error("result or stall present after reset");

    a_ctrl_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != KIND_DATA |-> o_out_byte == 8'd0)
        else $error("byte not zero on done or error result");

    a_ctrl_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != KIND_DATA |-> o_last_of_run)
        else $error("done or error result not last of run");

endmodule

bind http_chunked_body_decoder hcbd_checker #(.COUNT_BITS(COUNT_BITS)) u_hcbd_checker (.*);
